// ===== rtl/jtl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_pkg
// Shared types for the JSON5 token lexer: one token word and the bundle of
// up to three tokens that a single input word can produce.
// ----------------------------------------------------------------------------
package jtl_pkg;

	localparam int unsigned MAX_TOKENS = 3;

	// configuration register indexes
	localparam logic [0:0] REG_SKIP_WS = 1'd0;
	localparam logic [0:0] REG_SKIP_CM = 1'd1;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
	} token_t;

	typedef struct packed {
		token_t [MAX_TOKENS-1:0] tok;
		logic   [1:0]            cnt;
	} bundle_t;

endpackage

`default_nettype wire

// ===== rtl/jtl_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_in_if
// Input channel: command and text byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jtl_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] text_byte;

	modport source(output valid, output cmd, output text_byte, input ready);
	modport sink(input valid, input cmd, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/jtl_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_out_if
// Output channel: one token per word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jtl_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_offset;
	logic [15:0] token_length;
	logic        final_result;

	modport source(output valid, output token_kind, output token_offset,
		output token_length, output final_result, input ready);
	modport sink(input valid, input token_kind, input token_offset,
		input token_length, input final_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/json5_token_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json5_token_lexer
// JSON5 tokenizer top level: configuration registers, lexer core, queue.
// ----------------------------------------------------------------------------
// Tokens of a byte are formed combinationally and registered in the bundle queue.
// Throughput: one byte per cycle while the queue has space; a byte that yields
//   n tokens offers them one after another on the single token output port.
// Input stalls only when the two-entry bundle queue is full.
// Reset (arst_n low) clears lexer state and queue; both skip bits set to 1.
module json5_token_lexer
	import jtl_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	jtl_in_if.sink           byte_in,
	jtl_out_if.source        token_out,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [0:0]  cfg_data
);

	logic    skip_ws_q, skip_cm_q;
	logic    take;
	logic    space;
	bundle_t bundle;
	token_t  tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_ws_q <= 1'b1;
			skip_cm_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SKIP_WS: skip_ws_q <= cfg_data[0];
				REG_SKIP_CM: skip_cm_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign byte_in.ready = space;
	assign take = byte_in.valid && space;

	jtl_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (byte_in.cmd),
		.text_byte (byte_in.text_byte),
		.skip_ws   (skip_ws_q),
		.skip_cm   (skip_cm_q),
		.bundle    (bundle)
	);

	jtl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && bundle.cnt != 2'd0),
		.push_data (bundle),
		.space     (space),
		.valid     (token_out.valid),
		.ready     (token_out.ready),
		.tok       (tok),
		.last      (token_out.final_result)
	);

	assign token_out.token_kind   = tok.kind;
	assign token_out.token_offset = tok.offset;
	assign token_out.token_length = tok.length;

endmodule

`default_nettype wire

// ===== rtl/jtl_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_core
// Lexer state and next-state logic. On each accepted word the state is
// updated and the tokens that the word produces are presented as a bundle.
// ----------------------------------------------------------------------------
module jtl_core
	import jtl_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       cmd,
	input  wire logic [7:0] text_byte,
	input  wire logic       skip_ws,
	input  wire logic       skip_cm,
	output bundle_t         bundle
);

	localparam int unsigned OB = OFFSET_BITS;

	typedef enum logic [10:0] {
		M_IDLE    = 11'b000_0000_0001,
		M_SLASH   = 11'b000_0000_0010,
		M_LINE    = 11'b000_0000_0100,
		M_LINE_CR = 11'b000_0000_1000,
		M_BLOCK   = 11'b000_0001_0000,
		M_ZERO    = 11'b000_0010_0000,
		M_ZERO_X  = 11'b000_0100_0000,
		M_HEX     = 11'b000_1000_0000,
		M_DEC     = 11'b001_0000_0000,
		M_IDENT   = 11'b010_0000_0000,
		M_HALT    = 11'b100_0000_0000
	} mode_t;

	localparam logic [3:0] K_INVALID = 4'd0;
	localparam logic [3:0] K_EOF     = 4'd1;
	localparam logic [3:0] K_LBRACE  = 4'd2;
	localparam logic [3:0] K_RBRACE  = 4'd3;
	localparam logic [3:0] K_LSQUARE = 4'd4;
	localparam logic [3:0] K_RSQUARE = 4'd5;
	localparam logic [3:0] K_COLON   = 4'd6;
	localparam logic [3:0] K_COMMA   = 4'd7;
	localparam logic [3:0] K_POINT   = 4'd8;
	localparam logic [3:0] K_PLUS    = 4'd9;
	localparam logic [3:0] K_MINUS   = 4'd10;
	localparam logic [3:0] K_SQUOTE  = 4'd11;
	localparam logic [3:0] K_DQUOTE  = 4'd12;
	localparam logic [3:0] K_DECIMAL = 4'd13;
	localparam logic [3:0] K_HEX     = 4'd14;
	localparam logic [3:0] K_IDENT   = 4'd15;

	localparam logic [7:0] C_LF     = 8'h0A;
	localparam logic [7:0] C_CR     = 8'h0D;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_US     = 8'h5F;
	localparam logic [7:0] C_SLASH  = 8'h2F;
	localparam logic [7:0] C_STAR   = 8'h2A;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_ZERO   = 8'h30;
	localparam logic [7:0] C_X_LO   = 8'h78;
	localparam logic [7:0] C_X_UP   = 8'h58;
	// U+2028 / U+2029 are E2 80 A8 / E2 80 A9
	localparam logic [7:0] C_LS0    = 8'hE2;
	localparam logic [7:0] C_LS1    = 8'h80;
	localparam logic [7:0] C_LS2    = 8'hA8;
	localparam logic [7:0] C_PS2    = 8'hA9;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha_us(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == C_US;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c == C_SPACE || c == C_TAB || c == C_LF || c == C_CR;
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h5B:   k = K_LSQUARE;
			8'h5D:   k = K_RSQUARE;
			8'h3A:   k = K_COLON;
			8'h2C:   k = K_COMMA;
			8'h2E:   k = K_POINT;
			8'h2B:   k = K_PLUS;
			8'h2D:   k = K_MINUS;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
		return (v == {OB{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] clip16(input logic [OB-1:0] v);
		logic [32:0] e;
		e = 33'(v);
		return (e > 33'd65535) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic token_t mk(input logic [3:0] k, input logic [OB-1:0] off,
		input logic [OB-1:0] len);
		token_t t;
		t.kind   = k;
		t.offset = clip16(off);
		t.length = clip16(len);
		return t;
	endfunction

	mode_t         mode_q;
	logic [7:0]    held0_q, held1_q;
	logic [1:0]    held_cnt_q;
	logic [OB-1:0] byte_off_q;
	logic [OB-1:0] tok_begin_q;
	logic          cr_seen_q;
	logic [2:0]    utf8_q;
	logic          star_q;

	mode_t         m;
	logic [7:0]    h0, h1;
	logic [1:0]    hc;
	logic [OB-1:0] off_n;
	logic [OB-1:0] tb;
	logic          cr;
	logic [2:0]    u8;
	logic          st;
	bundle_t       b;

	always_comb begin
		logic [7:0]    c;
		logic [OB-1:0] pos;
		logic [OB-1:0] tb1;
		logic          do_start;
		logic [7:0]    lo, hi;
		logic [1:0]    n;
		logic [3:0]    sk;

		c   = text_byte;
		pos = byte_off_q;
		m   = mode_q;
		h0  = held0_q;
		h1  = held1_q;
		hc  = held_cnt_q;
		tb  = tok_begin_q;
		cr  = cr_seen_q;
		u8  = utf8_q;
		st  = star_q;
		off_n = byte_off_q;
		do_start = 1'b0;
		tb1 = sat_inc(tok_begin_q);
		lo = 8'h80;
		hi = 8'hBF;
		n  = 2'd0;
		sk = single_kind(c);
		b.tok = '0;

		if (cmd) begin
			unique case (mode_q)
				M_SLASH: begin
					b.tok[n] = mk(K_INVALID, tok_begin_q, '0); n = n + 2'd1;
				end
				M_LINE: begin
					if (utf8_q != 3'd0) begin
						b.tok[n] = mk(K_INVALID, tok_begin_q, '0); n = n + 2'd1;
					end
				end
				M_ZERO: begin
					b.tok[n] = mk(K_DECIMAL, tok_begin_q, OB'(1)); n = n + 2'd1;
				end
				M_ZERO_X: begin
					b.tok[n] = mk(K_DECIMAL, tok_begin_q, OB'(1)); n = n + 2'd1;
					b.tok[n] = mk(K_IDENT, tb1, OB'(1)); n = n + 2'd1;
				end
				M_HEX: begin
					b.tok[n] = mk(K_HEX, tok_begin_q, byte_off_q - tok_begin_q);
					n = n + 2'd1;
				end
				M_DEC: begin
					b.tok[n] = mk(K_DECIMAL, tok_begin_q, byte_off_q - tok_begin_q);
					n = n + 2'd1;
				end
				M_IDENT: begin
					b.tok[n] = mk(K_IDENT, tok_begin_q, byte_off_q - tok_begin_q);
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			b.tok[n] = mk(K_EOF, byte_off_q, '0); n = n + 2'd1;
			m = M_IDLE; h0 = '0; h1 = '0; hc = '0; off_n = '0; tb = '0;
			cr = 1'b0; u8 = '0; st = 1'b0;
		end else begin
			off_n = sat_inc(byte_off_q);
			unique case (mode_q)
				M_IDLE: do_start = 1'b1;
				M_SLASH: begin
					hc = 2'd0;
					if (c == C_SLASH) begin
						m = M_LINE; u8 = 3'd0;
					end else if (c == C_STAR) begin
						m = M_BLOCK; st = 1'b0;
					end else begin
						b.tok[n] = mk(K_INVALID, tok_begin_q, '0); n = n + 2'd1;
						m = M_HALT;
					end
				end
				M_LINE: begin
					if (utf8_q == 3'd0) begin
						if (c < 8'h80) begin
							if (c == C_LF) begin
								m = M_IDLE;
							end else if (c == C_CR) begin
								m = M_LINE_CR; cr = 1'b1;
							end
						end else if (c >= 8'hC2 && c <= 8'hDF) begin
							u8 = 3'd1; h0 = c; hc = 2'd1; tb = pos;
						end else if (c >= 8'hE0 && c <= 8'hEF) begin
							u8 = 3'd2; h0 = c; hc = 2'd1; tb = pos;
						end else if (c >= 8'hF0 && c <= 8'hF4) begin
							u8 = 3'd3; h0 = c; hc = 2'd1; tb = pos;
						end else begin
							// bad lead byte ends the comment and is lexed itself
							m = M_IDLE; do_start = 1'b1;
						end
					end else begin
						if (held_cnt_q == 2'd1) begin
							if (held0_q == 8'hE0) lo = 8'hA0;
							else if (held0_q == 8'hED) hi = 8'h9F;
							else if (held0_q == 8'hF0) lo = 8'h90;
							else if (held0_q == 8'hF4) hi = 8'h8F;
						end
						if (c < lo || c > hi) begin
							b.tok[n] = mk(K_INVALID, tok_begin_q, '0); n = n + 2'd1;
							m = M_HALT; u8 = 3'd0; hc = 2'd0;
						end else begin
							if (held_cnt_q == 2'd0) begin
								h0 = c; hc = 2'd1;
							end else if (held_cnt_q == 2'd1) begin
								h1 = c; hc = 2'd2;
							end
							u8 = utf8_q - 3'd1;
							if (u8 == 3'd0) begin
								if (h0 == C_LS0 && h1 == C_LS1 && (c == C_LS2 || c == C_PS2))
									m = M_IDLE;
								hc = 2'd0;
							end
						end
					end
				end
				M_LINE_CR: begin
					cr = 1'b0; m = M_IDLE;
					if (c != C_LF) do_start = 1'b1;
				end
				M_BLOCK: begin
					if (star_q && c == C_SLASH) begin
						m = M_IDLE; st = 1'b0;
					end else begin
						st = (c == C_STAR);
					end
				end
				M_ZERO: begin
					if (c == C_X_LO || c == C_X_UP) begin
						m = M_ZERO_X; h1 = c; hc = 2'd2;
					end else begin
						hc = 2'd0;
						b.tok[n] = mk(K_DECIMAL, tok_begin_q, OB'(1)); n = n + 2'd1;
						m = M_IDLE; do_start = 1'b1;
					end
				end
				M_ZERO_X: begin
					hc = 2'd0;
					if (is_hex(c)) begin
						m = M_HEX;
					end else begin
						// "0" then the x opens an identifier one byte on
						b.tok[n] = mk(K_DECIMAL, tok_begin_q, OB'(1)); n = n + 2'd1;
						tb = tb1;
						if (is_alpha_us(c) || is_digit(c)) begin
							m = M_IDENT;
						end else begin
							b.tok[n] = mk(K_IDENT, tb1, pos - tb1); n = n + 2'd1;
							m = M_IDLE; do_start = 1'b1;
						end
					end
				end
				M_HEX: begin
					if (!is_hex(c)) begin
						b.tok[n] = mk(K_HEX, tok_begin_q, pos - tok_begin_q);
						n = n + 2'd1;
						m = M_IDLE; do_start = 1'b1;
					end
				end
				M_DEC: begin
					if (!is_digit(c)) begin
						b.tok[n] = mk(K_DECIMAL, tok_begin_q, pos - tok_begin_q);
						n = n + 2'd1;
						m = M_IDLE; do_start = 1'b1;
					end
				end
				M_IDENT: begin
					if (!(is_alpha_us(c) || is_digit(c))) begin
						b.tok[n] = mk(K_IDENT, tok_begin_q, pos - tok_begin_q);
						n = n + 2'd1;
						m = M_IDLE; do_start = 1'b1;
					end
				end
				M_HALT: begin
				end
				default: begin
					m = M_IDLE; do_start = 1'b1;
				end
			endcase

			if (do_start) begin
				priority if (skip_ws && is_ws(c)) begin
				end else if (skip_cm && c == C_SLASH) begin
					m = M_SLASH; tb = pos; h0 = c; hc = 2'd1;
				end else if (sk != K_INVALID) begin
					b.tok[n] = mk(sk, pos, OB'(1)); n = n + 2'd1;
				end else if (c == C_SQUOTE || c == C_DQUOTE) begin
					b.tok[n] = mk((c == C_SQUOTE) ? K_SQUOTE : K_DQUOTE, pos, '0);
					n = n + 2'd1;
					m = M_HALT;
				end else begin
					tb = pos;
					if (c == C_ZERO) begin
						m = M_ZERO; h0 = c; hc = 2'd1;
					end else if (c >= 8'h31 && c <= 8'h39) begin
						m = M_DEC;
					end else if (is_alpha_us(c)) begin
						m = M_IDENT;
					end else begin
						b.tok[n] = mk(K_INVALID, pos, '0); n = n + 2'd1;
						m = M_HALT;
					end
				end
			end
		end
		b.cnt = n;
	end

	assign bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			held0_q     <= '0;
			held1_q     <= '0;
			held_cnt_q  <= '0;
			byte_off_q  <= '0;
			tok_begin_q <= '0;
			cr_seen_q   <= 1'b0;
			utf8_q      <= '0;
			star_q      <= 1'b0;
		end else if (take) begin
			mode_q      <= m;
			held0_q     <= h0;
			held1_q     <= h1;
			held_cnt_q  <= hc;
			byte_off_q  <= off_n;
			tok_begin_q <= tb;
			cr_seen_q   <= cr;
			utf8_q      <= u8;
			star_q      <= st;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_LINE_CR) |-> cr_seen_q)
		else $error("CR mode without CR flag");
	assert property (@(posedge clk) disable iff (!arst_n)
		(utf8_q != 3'd0) |-> (mode_q == M_LINE && held_cnt_q != 2'd0))
		else $error("UTF-8 progress outside a line comment");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd) |=> (byte_off_q == '0 && mode_q == M_IDLE))
		else $error("state not cleared after end of input");

endmodule

`default_nettype wire

// ===== rtl/jtl_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_queue
// Two-entry bundle queue; drains one token word per cycle to the output while ready is high.
// ----------------------------------------------------------------------------
module jtl_queue
	import jtl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  bundle_t      push_data,
	output logic         space,
	output logic         valid,
	input  wire logic    ready,
	output token_t       tok,
	output logic         last
);

	bundle_t    q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic [1:0] idx_q;
	bundle_t    head;
	logic       take_out, pop, do_push;

	assign head     = q_q[rd_q];
	assign space    = (cnt_q != 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign tok      = head.tok[idx_q];
	assign last     = (idx_q == head.cnt - 2'd1);
	assign take_out = valid && ready;
	assign pop      = take_out && last;
	assign do_push  = push && space;

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (pop) begin
				rd_q  <= ~rd_q;
				idx_q <= '0;
			end else if (take_out) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (head.cnt != 2'd0 && idx_q < head.cnt))
		else $error("token index beyond bundle");
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> (idx_q == 2'd0 && rd_q == wr_q))
		else $error("empty queue with stale pointers");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - JSON5 token lexer testbench
// Drives bytes and end-of-text words into the lexer, predicts every token
// word with an in-bench lexer model and checks each accepted token word in
// order. A short directed table comes first, then random JSON5-like texts
// under random skip settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import jtl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		LX_IDLE, LX_SLASH, LX_LINE, LX_LINE_CR, LX_BLOCK, LX_ZERO, LX_ZERO_X,
		LX_HEX, LX_DEC, LX_IDENT, LX_HALT
	} lex_mode_e;

	typedef enum logic [3:0] {
		TK_INVALID, TK_EOF, TK_LBRACE, TK_RBRACE, TK_LSQUARE, TK_RSQUARE,
		TK_COLON, TK_COMMA, TK_POINT, TK_PLUS, TK_MINUS, TK_SQUOTE, TK_DQUOTE,
		TK_DECIMAL, TK_HEX, TK_IDENT
	} tok_kind_e;

	localparam bit CMD_BYTE = 1'b0;
	localparam bit CMD_END = 1'b1;
	localparam int unsigned OFF_MAX = 65535;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		token_t tok;
		logic   fin;
	} tok_word_t;

	typedef struct {
		bit        cmd;
		bit [7:0]  b;
		bit        typed;
		tok_kind_e kind;
		int        off;
		int        len;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_index = 0;
	logic [0:0] cfg_data = 0;

	jtl_in_if byte_in();
	jtl_out_if token_out();

	json5_token_lexer i_dut (
		.clk(clk), .arst_n(arst_n), .byte_in(byte_in), .token_out(token_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		byte_in.valid = 0;
		byte_in.cmd = 0;
		byte_in.text_byte = 0;
		token_out.ready = 0;
	end

	// lexer model state
	bit sk_ws = 1, sk_cm = 1;
	lex_mode_e mode = LX_IDLE;
	bit [7:0] hb0, hb1;
	int hcnt, u8p;
	int unsigned boff, tbeg;
	bit crs, star;
	tok_word_t step_q[$];
	tok_word_t token_q[$];

	int errs = 0;
	bit idle_on = 1;
	bit hold_req = 0;
	int cycles = 0;
	int sent_words = 0;

	function automatic int unsigned sat_inc(int unsigned v);
		return v < OFF_MAX ? v + 1 : v;
	endfunction

	function automatic void emit(tok_kind_e k, int unsigned off, int unsigned len);
		tok_word_t w;
		if (step_q.size() >= MAX_TOKENS) return;
		w.tok.kind = k;
		w.tok.offset = off > OFF_MAX ? OFF_MAX : off;
		w.tok.length = len > OFF_MAX ? OFF_MAX : len;
		w.fin = 0;
		step_q.push_back(w);
	endfunction

	function automatic bit is_alpha(bit [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction
	function automatic bit is_dig(bit [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit is_hexd(bit [7:0] c);
		return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction
	function automatic bit is_space(bit [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic void clear_lexer();
		mode = LX_IDLE; hb0 = 0; hb1 = 0; hcnt = 0; boff = 0; tbeg = 0;
		crs = 0; u8p = 0; star = 0;
	endfunction

	function automatic void start_tok(bit [7:0] c, int unsigned pos);
		tok_kind_e k;
		k = TK_INVALID;
		if (sk_ws && is_space(c)) return;
		if (sk_cm && c == "/") begin
			mode = LX_SLASH; tbeg = pos; hb0 = c; hcnt = 1;
			return;
		end
		case (c)
			"{": k = TK_LBRACE;
			"}": k = TK_RBRACE;
			"[": k = TK_LSQUARE;
			"]": k = TK_RSQUARE;
			":": k = TK_COLON;
			",": k = TK_COMMA;
			".": k = TK_POINT;
			"+": k = TK_PLUS;
			"-": k = TK_MINUS;
			default: k = TK_INVALID;
		endcase
		if (k != TK_INVALID) begin
			emit(k, pos, 1);
			return;
		end
		if (c == 8'h27 || c == 8'h22) begin
			emit(c == 8'h27 ? TK_SQUOTE : TK_DQUOTE, pos, 0);
			mode = LX_HALT;
			return;
		end
		tbeg = pos;
		if (c == "0") begin
			mode = LX_ZERO; hb0 = c; hcnt = 1;
		end else if (c >= "1" && c <= "9") begin
			mode = LX_DEC;
		end else if (is_alpha(c)) begin
			mode = LX_IDENT;
		end else begin
			emit(TK_INVALID, pos, 0);
			mode = LX_HALT;
		end
	endfunction

	function automatic void line_comment(bit [7:0] c, int unsigned pos);
		bit [7:0] lo, hi;
		if (u8p == 0) begin
			if (c < 8'h80) begin
				if (c == 8'h0A) mode = LX_IDLE;
				else if (c == 8'h0D) begin
					mode = LX_LINE_CR; crs = 1;
				end
				return;
			end
			if (c >= 8'hC2 && c <= 8'hDF) u8p = 1;
			else if (c >= 8'hE0 && c <= 8'hEF) u8p = 2;
			else if (c >= 8'hF0 && c <= 8'hF4) u8p = 3;
			else begin
				// bad lead byte closes the comment and is lexed itself
				mode = LX_IDLE;
				start_tok(c, pos);
				return;
			end
			hb0 = c; hcnt = 1; tbeg = pos;
			return;
		end
		lo = 8'h80; hi = 8'hBF;
		if (hcnt == 1) begin
			if (hb0 == 8'hE0) lo = 8'hA0;
			else if (hb0 == 8'hED) hi = 8'h9F;
			else if (hb0 == 8'hF0) lo = 8'h90;
			else if (hb0 == 8'hF4) hi = 8'h8F;
		end
		if (c < lo || c > hi) begin
			emit(TK_INVALID, tbeg, 0);
			mode = LX_HALT; u8p = 0; hcnt = 0;
			return;
		end
		if (hcnt < 2) begin
			if (hcnt == 0) hb0 = c; else hb1 = c;
			hcnt++;
		end
		u8p--;
		if (u8p == 0) begin
			if (hb0 == 8'hE2 && hb1 == 8'h80 && (c == 8'hA8 || c == 8'hA9))
				mode = LX_IDLE;
			hcnt = 0;
		end
	endfunction

	function automatic void lex_one(bit [7:0] c, int unsigned pos);
		bit more;
		tok_kind_e k;
		forever begin
			case (mode)
				LX_IDLE: begin
					start_tok(c, pos);
					return;
				end
				LX_SLASH: begin
					hcnt = 0;
					if (c == "/") begin
						mode = LX_LINE; u8p = 0;
					end else if (c == "*") begin
						mode = LX_BLOCK; star = 0;
					end else begin
						emit(TK_INVALID, tbeg, 0);
						mode = LX_HALT;
					end
					return;
				end
				LX_LINE: begin
					line_comment(c, pos);
					return;
				end
				LX_LINE_CR: begin
					crs = 0;
					mode = LX_IDLE;
					if (c == 8'h0A) return;
				end
				LX_BLOCK: begin
					if (star && c == "/") begin
						mode = LX_IDLE; star = 0;
					end else star = (c == "*");
					return;
				end
				LX_ZERO: begin
					if (c == "x" || c == "X") begin
						mode = LX_ZERO_X; hb1 = c; hcnt = 2;
						return;
					end
					hcnt = 0;
					emit(TK_DECIMAL, tbeg, 1);
					mode = LX_IDLE;
				end
				LX_ZERO_X: begin
					hcnt = 0;
					if (is_hexd(c)) begin
						mode = LX_HEX;
						return;
					end
					emit(TK_DECIMAL, tbeg, 1);
					mode = LX_IDLE;
					start_tok(hb1, sat_inc(tbeg));
				end
				LX_HEX, LX_DEC, LX_IDENT: begin
					if (mode == LX_HEX) begin
						more = is_hexd(c); k = TK_HEX;
					end else if (mode == LX_DEC) begin
						more = is_dig(c); k = TK_DECIMAL;
					end else begin
						more = is_alpha(c) || is_dig(c); k = TK_IDENT;
					end
					if (more) return;
					emit(k, tbeg, pos - tbeg);
					mode = LX_IDLE;
				end
				LX_HALT: return;
				default: mode = LX_IDLE;
			endcase
		end
	endfunction

	function automatic void end_text();
		case (mode)
			LX_SLASH: emit(TK_INVALID, tbeg, 0);
			LX_LINE: if (u8p != 0) emit(TK_INVALID, tbeg, 0);
			LX_ZERO: emit(TK_DECIMAL, tbeg, 1);
			LX_ZERO_X: begin
				emit(TK_DECIMAL, tbeg, 1);
				emit(TK_IDENT, sat_inc(tbeg), 1);
			end
			LX_HEX: emit(TK_HEX, tbeg, boff - tbeg);
			LX_DEC: emit(TK_DECIMAL, tbeg, boff - tbeg);
			LX_IDENT: emit(TK_IDENT, tbeg, boff - tbeg);
			default: ;
		endcase
		emit(TK_EOF, boff, 0);
		clear_lexer();
	endfunction

	// predicts the token words of one accepted input word
	function automatic void predict_tokens(bit cmd, bit [7:0] b);
		int unsigned pos;
		step_q.delete();
		if (cmd == CMD_END) end_text();
		else begin
			pos = boff;
			boff = sat_inc(boff);
			lex_one(b, pos);
		end
		if (step_q.size() > 0) step_q[step_q.size()-1].fin = 1;
		foreach (step_q[i]) token_q.push_back(step_q[i]);
	endfunction

	// ---------------------------------------------------------------- driver
	task automatic send_word(bit cmd, bit [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			byte_in.valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		byte_in.valid <= 1;
		byte_in.cmd <= cmd;
		byte_in.text_byte <= b;
		do @(posedge clk); while (!byte_in.ready);
		sent_words++;
		predict_tokens(cmd, b);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_word(CMD_BYTE, s[i]);
	endtask

	task automatic drain_tokens();
		byte_in.valid <= 0;
		@(posedge clk);
		while (token_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_skip(bit ws, bit cm);
		drain_tokens();
		cfg_we <= 1; cfg_index <= REG_SKIP_WS; cfg_data <= ws;
		@(posedge clk);
		cfg_index <= REG_SKIP_CM; cfg_data <= cm;
		@(posedge clk);
		cfg_we <= 0;
		sk_ws = ws; sk_cm = cm;
		@(posedge clk);
	endtask

	function automatic bit [7:0] pick(string s);
		return s[$urandom_range(0, s.len()-1)];
	endfunction

	task automatic send_segment();
		int n;
		string letters, txt;
		letters = "abcxyzXQ_";
		txt = "";
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				txt = {txt, pick(letters)};
				n = $urandom_range(0, 5);
				repeat (n) txt = {txt, pick("az_Z09x")};
			end
			3, 4: begin
				txt = {txt, pick("123456789")};
				repeat ($urandom_range(0, 4)) txt = {txt, pick("0123456789")};
			end
			5: begin
				txt = "0x";
				repeat ($urandom_range(1, 4)) txt = {txt, pick("09afAFc")};
			end
			6: txt = $urandom_range(0, 1) ? "0" : {"0", pick("xX"), pick("g_.,:z ")};
			7, 8, 9: txt = {txt, pick("{}[]:,.+-")};
			10, 11: repeat ($urandom_range(1, 3)) txt = {txt, pick(" \t\r\n")};
			12, 13, 14: begin
				txt = "//";
				repeat ($urandom_range(0, 4)) txt = {txt, pick("ab */\t")};
				case ($urandom_range(0, 9))
					0: txt = {txt, 8'hC3, 8'hA9, "\n"};
					1: txt = {txt, 8'hE2, 8'h82, 8'hAC, 8'hED, 8'h9F, 8'hBF, "\r\n"};
					2: txt = {txt, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF,
						8'hBF, "\n"};
					3: txt = {txt, 8'hE2, 8'h80, 8'hA8};
					4: txt = {txt, 8'hE2, 8'h80, 8'hA9};
					5: txt = {txt, "\r"};
					6: case ($urandom_range(0, 5))
						0: txt = {txt, 8'hC0};
						1: txt = {txt, 8'h80};
						2: txt = {txt, 8'hE0, 8'h80};
						3: txt = {txt, 8'hED, 8'hA0};
						4: txt = {txt, 8'hF4, 8'h90};
						default: txt = {txt, 8'hF5};
					endcase
					default: txt = {txt, "\n"};
				endcase
			end
			15, 16: begin
				txt = "/*";
				repeat ($urandom_range(0, 5)) txt = {txt, pick("a**/ \n")};
				txt = {txt, "*/"};
			end
			17: txt = {"/", pick("a1{ ")};
			default: begin
				// noise: any byte or an end-of-text word, may stop lexing
				send_word($urandom_range(0, 7) == 0, $urandom_range(0, 255));
				return;
			end
		endcase
		send_text(txt);
	endtask

	stim_row_t dir_tab[$];

	function automatic stim_row_t row(bit cmd, bit [7:0] b, bit typed = 0,
			tok_kind_e k = TK_INVALID, int off = 0, int len = 0);
		stim_row_t r;
		r.cmd = cmd; r.b = b; r.typed = typed; r.kind = k; r.off = off; r.len = len;
		return r;
	endfunction

	initial begin
		int docs;
		bit [1:0] setting;
		clear_lexer();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir_tab.push_back(row(CMD_END, 0, 1, TK_EOF, 0, 0));
		dir_tab.push_back(row(CMD_BYTE, "{", 1, TK_LBRACE, 0, 1));
		dir_tab.push_back(row(CMD_BYTE, "}"));
		dir_tab.push_back(row(CMD_BYTE, "["));
		dir_tab.push_back(row(CMD_BYTE, "]"));
		dir_tab.push_back(row(CMD_BYTE, ":"));
		dir_tab.push_back(row(CMD_BYTE, ","));
		dir_tab.push_back(row(CMD_BYTE, "."));
		dir_tab.push_back(row(CMD_BYTE, "+"));
		dir_tab.push_back(row(CMD_BYTE, "-"));
		dir_tab.push_back(row(CMD_BYTE, "1"));
		dir_tab.push_back(row(CMD_BYTE, "2"));
		dir_tab.push_back(row(CMD_BYTE, " "));
		dir_tab.push_back(row(CMD_BYTE, "0"));
		dir_tab.push_back(row(CMD_BYTE, "x"));
		dir_tab.push_back(row(CMD_BYTE, "g"));
		dir_tab.push_back(row(CMD_BYTE, "/"));
		dir_tab.push_back(row(CMD_BYTE, "/"));
		dir_tab.push_back(row(CMD_BYTE, 8'hE2));
		dir_tab.push_back(row(CMD_BYTE, 8'h80));
		dir_tab.push_back(row(CMD_BYTE, 8'hA8));
		dir_tab.push_back(row(CMD_BYTE, "a"));
		dir_tab.push_back(row(CMD_END, 0));
		dir_tab.push_back(row(CMD_BYTE, 8'h27, 1, TK_SQUOTE, 0, 0));
		dir_tab.push_back(row(CMD_BYTE, 8'hFF));
		dir_tab.push_back(row(CMD_END, 0, 1, TK_EOF, 2, 0));

		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].cmd, dir_tab[i].b);
			if (dir_tab[i].typed && (step_q.size() == 0 ||
					step_q[0].tok.kind != dir_tab[i].kind ||
					step_q[0].tok.offset != dir_tab[i].off ||
					step_q[0].tok.length != dir_tab[i].len)) begin
				errs++;
				if (errs <= 10) begin
					if (step_q.size() == 0)
						$display("directed row %0d: exp k%0d o%0d l%0d got no token",
							i, dir_tab[i].kind, dir_tab[i].off, dir_tab[i].len);
					else
						$display("directed row %0d: exp k%0d o%0d l%0d got k%0d o%0d l%0d",
							i, dir_tab[i].kind, dir_tab[i].off, dir_tab[i].len,
							step_q[0].tok.kind, step_q[0].tok.offset,
							step_q[0].tok.length);
				end
			end
		end

		docs = 0;
		while (sent_words < 420) begin
			if (docs % 3 == 2) begin
				setting = $urandom_range(0, 3);
				write_skip(setting[0], setting[1]);
			end
			if (docs == 4) begin
				// receiver holds off while words keep coming
				idle_on = 0;
				hold_req = 1;
			end
			if (docs == 6) begin
				idle_on = 1;
				drain_tokens();
			end
			if (sent_words > 380) idle_on = 0;
			repeat ($urandom_range(3, 12)) send_segment();
			send_word(CMD_END, 0);
			docs++;
		end
		write_skip(1, 1);
		send_text("ab 0x1f//c\n/*x*/-");
		send_word(CMD_END, 0);
		byte_in.valid <= 0;

		while (token_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------- receiver
	int rx_hold = 0;
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			rx_hold = 300;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			token_out.ready <= 0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rx_hold = $urandom_range(0, 7);
			token_out.ready <= 0;
		end else begin
			token_out.ready <= 1;
		end
	end

	// checks each accepted token word against the oldest prediction
	always @(posedge clk) begin
		tok_word_t w;
		if (arst_n && token_out.valid && token_out.ready) begin
			if (token_q.size() == 0) begin
				errs++;
				if (errs <= 10) $display("unexpected token word kind %0d",
					token_out.token_kind);
			end else begin
				w = token_q.pop_front();
				if (token_out.token_kind !== w.tok.kind ||
						token_out.token_offset !== w.tok.offset ||
						token_out.token_length !== w.tok.length ||
						token_out.final_result !== w.fin) begin
					errs++;
					if (errs <= 10)
						$display("token mismatch: exp k%0d o%0d l%0d f%0d got k%0d o%0d l%0d f%0d",
							w.tok.kind, w.tok.offset, w.tok.length, w.fin,
							token_out.token_kind, token_out.token_offset,
							token_out.token_length, token_out.final_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
